// ===== hdl/socks5_client_handshake_assert.svh =====
// Assertion macros shared by the RTL of the SOCKS5 client handshake block.
`ifndef SOCKS5_CLIENT_HANDSHAKE_ASSERT_SVH
`define SOCKS5_CLIENT_HANDSHAKE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define S5CH_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define S5CH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define S5CH_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define S5CH_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== hdl/s5ch_pkg.sv =====
// Types, codes and helper functions of the SOCKS5 client handshake block.
`timescale 1ns / 1ps

package s5ch_pkg;

    // Input item kinds, carried on s_tuser.
    typedef enum logic [1:0] {
        MODE_START     = 2'd0,
        MODE_NAME_BYTE = 2'd1,
        MODE_RX_BYTE   = 2'd2,
        MODE_LINK_ERR  = 2'd3
    } mode_t;

    // Handshake phases, one-hot.
    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_GREET = 5'b00010,
        PH_NAME  = 5'b00100,
        PH_HEAD  = 5'b01000,
        PH_TAIL  = 5'b10000
    } phase_t;

    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FAIL = 2'd1;
    localparam logic [1:0] STATUS_LINK = 2'd2;

    localparam logic [7:0] SOCKS_VERSION = 8'h05;
    localparam logic [7:0] CMD_CONNECT   = 8'h01;
    localparam logic [7:0] METHOD_NOAUTH = 8'h00;
    localparam logic [7:0] RESERVED_BYTE = 8'h00;
    localparam logic [7:0] REPLY_SUCCESS = 8'h00;
    localparam logic [7:0] ATYP_IPV4     = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
    localparam logic [7:0] ATYP_IPV6     = 8'h04;

    // Tail bytes left after the five header bytes: rest of the address plus the port.
    localparam logic [8:0] TAIL_IPV4 = 9'(10 - 5);
    localparam logic [8:0] TAIL_IPV6 = 9'(22 - 5);
    localparam logic [8:0] TAIL_DOMAIN_EXTRA = 9'(7 - 5);

    // Most results one input item can cause, and the burst buffer depth.
    localparam int BURST_MAX   = 7;
    localparam int BURST_DEPTH = 8;
    localparam int BURST_IDX_W = $clog2(BURST_DEPTH);

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic [1:0]  status;
        logic [15:0] bound_port;
    } res_t;

    function automatic res_t mk_tx(input logic [7:0] tx);
        res_t r;
        r.kind       = KIND_TX;
        r.tx_byte    = tx;
        r.status     = STATUS_OK;
        r.bound_port = 16'h0000;
        return r;
    endfunction

    function automatic res_t mk_report(input logic [1:0] st, input logic [15:0] port);
        res_t r;
        r.kind       = KIND_REPORT;
        r.tx_byte    = 8'h00;
        r.status     = st;
        r.bound_port = port;
        return r;
    endfunction

endpackage

// ===== hdl/socks5_client_handshake.sv =====
// SOCKS5 client handshake: no-auth CONNECT by domain name, stream in and stream out.
//
// The block takes one input item per cycle while s_tready is high. Each accepted item
// is decoded in the same cycle against the handshake state, and every result it causes
// (none, one, three, five or seven) is loaded at once into an eight-entry burst buffer
// that drains one result per cycle on the m_ side while m_tready is high, with m_tlast
// on the final result of the item. An item's results hold off the input until the last
// of them leaves; items with at most one result flow at one item per cycle while
// m_tready is high, since the next item is taken in the cycle that the last result of
// the previous one leaves. The burst buffer is the only thing that throttles s_tready.
`timescale 1ns / 1ps

`include "socks5_client_handshake_assert.svh"

module socks5_client_handshake
    import s5ch_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // data_byte[7:0], dest_port[23:8], name_length[31:24]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // tx_byte[7:0], status[9:8], bound_port[25:10], zero
    output logic        m_tuser,   // kind
    output logic        m_tlast
);

    phase_t      phase_reg, phase_next;
    logic [8:0]  byte_count_reg, byte_count_next;
    logic [7:0]  name_len_reg, name_len_next;
    logic [15:0] dest_port_reg, dest_port_next;
    logic        reply_ok_reg, reply_ok_next;
    logic [8:0]  tail_len_reg, tail_len_next;
    logic [15:0] port_cap_reg, port_cap_next;

    res_t                   res_reg [BURST_DEPTH];
    res_t                   res_next [BURST_DEPTH];
    logic [BURST_IDX_W-1:0] cnt_reg, cnt_next;
    logic [BURST_IDX_W-1:0] pos_reg;

    mode_t       mode;
    logic [7:0]  in_byte;
    logic        s_accept;
    logic        m_accept;
    logic [8:0]  count_inc;
    logic [15:0] cap_shift;
    logic        ver_ok;
    res_t        res_out;

    assign mode     = mode_t'(s_tuser);
    assign in_byte  = s_tdata[7:0];

    assign m_tvalid = (pos_reg != cnt_reg);
    assign m_tlast  = (BURST_IDX_W'(pos_reg + 1'b1) == cnt_reg);
    assign m_accept = m_tvalid && m_tready;
    // Free when the buffer is drained or its last result leaves in this cycle.
    assign s_tready = !m_tvalid || (m_tready && m_tlast);
    assign s_accept = s_tvalid && s_tready;

    assign res_out  = res_reg[pos_reg];
    assign m_tuser  = res_out.kind;
    assign m_tdata  = {6'b0, res_out.bound_port, res_out.status, res_out.tx_byte};

    assign count_inc = 9'(byte_count_reg + 1'b1);
    assign cap_shift = {port_cap_reg[7:0], in_byte};
    assign ver_ok    = (port_cap_reg == {8'h00, SOCKS_VERSION});

    always_comb begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        name_len_next   = name_len_reg;
        dest_port_next  = dest_port_reg;
        reply_ok_next   = reply_ok_reg;
        tail_len_next   = tail_len_reg;
        port_cap_next   = port_cap_reg;
        cnt_next        = '0;
        for (int i = 0; i < BURST_DEPTH; i++) begin
            res_next[i] = '0;
        end

        case (mode)
            MODE_START: begin
                if (phase_reg == PH_IDLE) begin
                    dest_port_next  = s_tdata[23:8];
                    name_len_next   = s_tdata[31:24];
                    res_next[0]     = mk_tx(SOCKS_VERSION);
                    res_next[1]     = mk_tx(CMD_CONNECT);
                    res_next[2]     = mk_tx(METHOD_NOAUTH);
                    cnt_next        = BURST_IDX_W'(3);
                    phase_next      = PH_GREET;
                    byte_count_next = '0;
                    reply_ok_next   = 1'b0;
                end
            end
            MODE_LINK_ERR: begin
                if (phase_reg != PH_IDLE) begin
                    res_next[0]     = mk_report(STATUS_LINK, 16'h0000);
                    cnt_next        = BURST_IDX_W'(1);
                    phase_next      = PH_IDLE;
                    byte_count_next = '0;
                end
            end
            MODE_NAME_BYTE: begin
                if (phase_reg == PH_NAME) begin
                    res_next[0]     = mk_tx(in_byte);
                    byte_count_next = count_inc;
                    if (count_inc >= {1'b0, name_len_reg}) begin
                        res_next[1]     = mk_tx(dest_port_reg[15:8]);
                        res_next[2]     = mk_tx(dest_port_reg[7:0]);
                        cnt_next        = BURST_IDX_W'(3);
                        phase_next      = PH_HEAD;
                        byte_count_next = '0;
                    end else begin
                        cnt_next = BURST_IDX_W'(1);
                    end
                end
            end
            MODE_RX_BYTE: begin
                case (phase_reg)
                    PH_GREET: begin
                        if (byte_count_reg == 9'd0) begin
                            reply_ok_next   = (in_byte == SOCKS_VERSION);
                            byte_count_next = 9'd1;
                        end else if (reply_ok_reg && in_byte == METHOD_NOAUTH) begin
                            res_next[0] = mk_tx(SOCKS_VERSION);
                            res_next[1] = mk_tx(CMD_CONNECT);
                            res_next[2] = mk_tx(RESERVED_BYTE);
                            res_next[3] = mk_tx(ATYP_DOMAIN);
                            res_next[4] = mk_tx(name_len_reg);
                            byte_count_next = '0;
                            // An empty name goes straight on to the port bytes.
                            if (name_len_reg == 8'd0) begin
                                res_next[5] = mk_tx(dest_port_reg[15:8]);
                                res_next[6] = mk_tx(dest_port_reg[7:0]);
                                cnt_next    = BURST_IDX_W'(BURST_MAX);
                                phase_next  = PH_HEAD;
                            end else begin
                                cnt_next   = BURST_IDX_W'(5);
                                phase_next = PH_NAME;
                            end
                        end else begin
                            res_next[0]     = mk_report(STATUS_FAIL, 16'h0000);
                            cnt_next        = BURST_IDX_W'(1);
                            phase_next      = PH_IDLE;
                            byte_count_next = '0;
                        end
                    end
                    PH_HEAD: begin
                        // The version byte waits in the port capture and the address
                        // type in the tail length until the fifth header byte.
                        if (byte_count_reg == 9'd0) begin
                            port_cap_next = {8'h00, in_byte};
                        end else if (byte_count_reg == 9'd1) begin
                            reply_ok_next = (in_byte == REPLY_SUCCESS);
                        end else if (byte_count_reg == 9'd3) begin
                            tail_len_next = {1'b0, in_byte};
                        end
                        if (byte_count_reg < 9'd4) begin
                            byte_count_next = count_inc;
                        end else begin
                            port_cap_next   = 16'h0000;
                            byte_count_next = '0;
                            phase_next      = PH_TAIL;
                            if (ver_ok && tail_len_reg == {1'b0, ATYP_IPV4}) begin
                                tail_len_next = TAIL_IPV4;
                            end else if (ver_ok && tail_len_reg == {1'b0, ATYP_DOMAIN}) begin
                                tail_len_next = 9'({1'b0, in_byte} + TAIL_DOMAIN_EXTRA);
                            end else if (ver_ok && tail_len_reg == {1'b0, ATYP_IPV6}) begin
                                tail_len_next = TAIL_IPV6;
                            end else begin
                                tail_len_next = '0;
                                res_next[0]   = mk_report(STATUS_FAIL, 16'h0000);
                                cnt_next      = BURST_IDX_W'(1);
                                phase_next    = PH_IDLE;
                            end
                        end
                    end
                    PH_TAIL: begin
                        port_cap_next   = cap_shift;
                        byte_count_next = count_inc;
                        if (count_inc >= tail_len_reg) begin
                            res_next[0]     = mk_report(reply_ok_reg ? STATUS_OK : STATUS_FAIL,
                                                        cap_shift);
                            cnt_next        = BURST_IDX_W'(1);
                            phase_next      = PH_IDLE;
                            byte_count_next = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            byte_count_reg <= '0;
            name_len_reg   <= '0;
            dest_port_reg  <= '0;
            reply_ok_reg   <= 1'b0;
            tail_len_reg   <= '0;
            port_cap_reg   <= '0;
            cnt_reg        <= '0;
            pos_reg        <= '0;
        end else if (s_accept) begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            name_len_reg   <= name_len_next;
            dest_port_reg  <= dest_port_next;
            reply_ok_reg   <= reply_ok_next;
            tail_len_reg   <= tail_len_next;
            port_cap_reg   <= port_cap_next;
            cnt_reg        <= cnt_next;
            pos_reg        <= '0;
        end else if (m_accept) begin
            pos_reg <= BURST_IDX_W'(pos_reg + 1'b1);
        end
    end

    // Burst payload carries no reset; the count and position say what is valid.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int i = 0; i < BURST_DEPTH; i++) begin
                res_reg[i] <= res_next[i];
            end
        end
    end

    `S5CH_ASSERT_IMPL(a_stall_needs_output, aclk, aresetn, !s_tready, m_tvalid)
    `S5CH_ASSERT_IMPL(a_pos_in_burst, aclk, aresetn, 1'b1, pos_reg <= cnt_reg)
    `S5CH_ASSERT_IMPL(a_idle_count_clear, aclk, aresetn, phase_reg == PH_IDLE,
                      byte_count_reg == 9'd0)
    `S5CH_ASSERT_IMPL(a_report_is_last, aclk, aresetn, m_tvalid && m_tuser == KIND_REPORT,
                      m_tlast)

endmodule
